### rtl/core/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define M4VT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define M4VT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/core/m4vt_pkg.sv
// ---------------------------------------------------------------------------
// m4vt_pkg
// Shared constants, types and the output shift/saturation function of the
// 4x4 fixed point transform engine.
// ---------------------------------------------------------------------------
package m4vt_pkg;

  localparam int unsigned DIM       = 4;   // matrix order, 2..4
  localparam int unsigned FRAC_BITS = 16;  // fraction bits of the element format
  localparam int unsigned NUM_ELEM  = 4;   // element fields carried by one beat
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned ROW_W     = 2;
  localparam int unsigned PROD_W    = 2 * ELEM_W;
  localparam int unsigned ACC_W     = PROD_W + 2;
  localparam int unsigned NUM_PAIR  = (DIM + 1) / 2;

  localparam logic [ELEM_W-1:0] ELEM_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] ELEM_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_XFORM = 1'b1
  } cmd_e;

  // per-lane load and stage enables
  typedef struct packed {
    logic load;
    logic en1;
    logic en2;
    logic en3;
  } lane_ctl_t;

  typedef struct packed {
    logic                     sat;
    logic signed [ELEM_W-1:0] val;
  } fin_t;

  // arithmetic shift by the fraction width, then clip to the element range
  function automatic fin_t finish_sum(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    fin_t                    res;
    sh      = acc >>> FRAC_BITS;
    res.sat = 1'b0;
    res.val = sh[ELEM_W-1:0];
    if (!sh[ACC_W-1] && (|sh[ACC_W-2:ELEM_W-1])) begin
      res.sat = 1'b1;
      res.val = ELEM_MAX;
    end else if (sh[ACC_W-1] && !(&sh[ACC_W-2:ELEM_W-1])) begin
      res.sat = 1'b1;
      res.val = ELEM_MIN;
    end
    return res;
  endfunction

endpackage

### rtl/core/m4vt_in_if.sv
// ---------------------------------------------------------------------------
// m4vt_in_if
// Input channel: a load-row or transform beat with four elements.
// ---------------------------------------------------------------------------
interface m4vt_in_if;
  import m4vt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic                     command;
  logic [ROW_W-1:0]         row_index;
  logic signed [ELEM_W-1:0] elem_0;
  logic signed [ELEM_W-1:0] elem_1;
  logic signed [ELEM_W-1:0] elem_2;
  logic signed [ELEM_W-1:0] elem_3;

  modport source (
    output valid, command, row_index, elem_0, elem_1, elem_2, elem_3,
    input  ready
  );

  modport sink (
    input  valid, command, row_index, elem_0, elem_1, elem_2, elem_3,
    output ready
  );

endinterface

### rtl/core/m4vt_out_if.sv
// ---------------------------------------------------------------------------
// m4vt_out_if
// Output channel: four transformed elements and the saturation flag.
// ---------------------------------------------------------------------------
interface m4vt_out_if;
  import m4vt_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] out_0;
  logic signed [ELEM_W-1:0] out_1;
  logic signed [ELEM_W-1:0] out_2;
  logic signed [ELEM_W-1:0] out_3;
  logic                     saturated;

  modport source (
    output valid, out_0, out_1, out_2, out_3, saturated,
    input  ready
  );

  modport sink (
    input  valid, out_0, out_1, out_2, out_3, saturated,
    output ready
  );

endinterface

### rtl/core/matrix4_vector_transform.sv
// path: lane product, pair and sum registers, then the merge output register
// throughput: one beat per cycle, loads and transforms alike, unless the
//   output stalls; a row load is seen by a transform taken in the next cycle
// the rate is set by the one multiplier per matrix element in the lanes
// reset: stored matrix cleared to zero, pipeline and output emptied
// ---------------------------------------------------------------------------
// matrix4_vector_transform
// 4x4 signed fixed point matrix by vector engine: one lane per row, a pair
// add and a final add stage, then a saturating merge into the output beat.
// ---------------------------------------------------------------------------
module matrix4_vector_transform (
  input  logic     clk_i,
  input  logic     rst_ni,
  m4vt_in_if.sink  in_i,
  m4vt_out_if.source out_o
);
  import m4vt_pkg::*;

  logic                     v1_q, v2_q, v3_q;
  logic                     v1_d, v2_d, v3_d;
  logic                     rdy1, rdy2, rdy3, rdy4;
  logic                     fire;
  logic                     xform;
  logic signed [ELEM_W-1:0] elem_all [NUM_ELEM];
  logic signed [ELEM_W-1:0] vec      [DIM];
  logic signed [ACC_W-1:0]  sums     [DIM];
  lane_ctl_t                ctl      [DIM];

  assign elem_all[0] = in_i.elem_0;
  assign elem_all[1] = in_i.elem_1;
  assign elem_all[2] = in_i.elem_2;
  assign elem_all[3] = in_i.elem_3;

  // each stage takes a beat when empty or when its successor moves
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign in_i.ready = rdy1;
  assign fire       = in_i.valid && rdy1;
  assign xform      = fire && (in_i.command == CMD_XFORM);

  assign v1_d = rdy1 ? xform : v1_q;
  assign v2_d = rdy2 ? v1_q  : v2_q;
  assign v3_d = rdy3 ? v2_q  : v3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  for (genvar r = 0; r < DIM; r++) begin : g_lane
    assign vec[r]      = elem_all[r];
    assign ctl[r].load = fire && (in_i.command == CMD_LOAD) &&
                         (in_i.row_index == ROW_W'(r));
    assign ctl[r].en1  = xform;
    assign ctl[r].en2  = v1_q && rdy2;
    assign ctl[r].en3  = v2_q && rdy3;

    m4vt_lane u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctl_i  (ctl[r]),
      .elem_i (vec),
      .sum_o  (sums[r])
    );
  end

  m4vt_merge u_merge (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v3_q),
    .ready_o (rdy4),
    .sum_i   (sums),
    .out_o   (out_o)
  );

endmodule

### rtl/core/m4vt_lane.sv
// ---------------------------------------------------------------------------
// m4vt_lane
// One matrix row: holds the row and forms its dot product with the vector
// over three register stages (multiply, pair add, final add).
// ---------------------------------------------------------------------------
module m4vt_lane (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  m4vt_pkg::lane_ctl_t                ctl_i,
  input  logic signed [m4vt_pkg::ELEM_W-1:0] elem_i [m4vt_pkg::DIM],
  output logic signed [m4vt_pkg::ACC_W-1:0]  sum_o
);
  import m4vt_pkg::*;

  logic signed [ELEM_W-1:0] row_q  [DIM];
  logic signed [PROD_W-1:0] prod_d [DIM];
  logic signed [PROD_W-1:0] prod_q [DIM];
  logic signed [ACC_W-1:0]  pair_d [NUM_PAIR];
  logic signed [ACC_W-1:0]  pair_q [NUM_PAIR];
  logic signed [ACC_W-1:0]  sum_d;
  logic signed [ACC_W-1:0]  sum_q;

  // stored row, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < DIM; c++) row_q[c] <= '0;
    end else if (ctl_i.load) begin
      for (int c = 0; c < DIM; c++) row_q[c] <= elem_i[c];
    end
  end

  always_comb begin
    for (int c = 0; c < DIM; c++) prod_d[c] = PROD_W'(row_q[c]) * PROD_W'(elem_i[c]);
  end

  always_comb begin
    for (int k = 0; k < NUM_PAIR; k++) begin
      pair_d[k] = ACC_W'(prod_q[2*k]);
      if (2*k + 1 < DIM) pair_d[k] = pair_d[k] + ACC_W'(prod_q[2*k+1]);
    end
  end

  always_comb begin
    sum_d = '0;
    for (int k = 0; k < NUM_PAIR; k++) sum_d = sum_d + pair_q[k];
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en1) prod_q <= prod_d;
    if (ctl_i.en2) pair_q <= pair_d;
    if (ctl_i.en3) sum_q  <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

### rtl/core/m4vt_merge.sv
// ---------------------------------------------------------------------------
// m4vt_merge
// Output stage: shifts and saturates each lane sum, ORs the lane flags and
// holds the result beat until the sink takes it.
// ---------------------------------------------------------------------------
module m4vt_merge (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  output logic                              ready_o,
  input  logic signed [m4vt_pkg::ACC_W-1:0] sum_i [m4vt_pkg::DIM],
  m4vt_out_if.source                        out_o
);
  import m4vt_pkg::*;

  logic                     valid_q;
  logic                     valid_d;
  logic                     load;
  fin_t                     fin      [NUM_ELEM];
  logic [NUM_ELEM-1:0]      sat_vec;
  logic signed [ELEM_W-1:0] res_q    [NUM_ELEM];
  logic                     sat_q;

  for (genvar r = 0; r < NUM_ELEM; r++) begin : g_fin
    if (r < DIM) begin : g_live
      assign fin[r] = finish_sum(sum_i[r]);
    end else begin : g_zero
      assign fin[r] = '0;
    end
    assign sat_vec[r] = fin[r].sat;
  end

  assign ready_o = !valid_q || out_o.ready;
  assign load    = ready_o && valid_i;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int r = 0; r < NUM_ELEM; r++) res_q[r] <= fin[r].val;
      sat_q <= |sat_vec;
    end
  end

  assign out_o.valid     = valid_q;
  assign out_o.out_0     = res_q[0];
  assign out_o.out_1     = res_q[1];
  assign out_o.out_2     = res_q[2];
  assign out_o.out_3     = res_q[3];
  assign out_o.saturated = sat_q;

endmodule

### rtl/core/m4vt_checker.sv
// ---------------------------------------------------------------------------
// m4vt_checker
// Port-level checks of the transform engine, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module m4vt_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [m4vt_pkg::ELEM_W-1:0] out_0,
  input logic signed [m4vt_pkg::ELEM_W-1:0] out_1,
  input logic signed [m4vt_pkg::ELEM_W-1:0] out_2,
  input logic signed [m4vt_pkg::ELEM_W-1:0] out_3,
  input logic                               saturated
);
  import m4vt_pkg::*;

  // a held beat keeps out_0, out_3 and the saturation flag
  `M4VT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_0) && $stable(out_3) && $stable(saturated), "output beat changed while stalled")

  // reset empties the output
  `M4VT_ASSERT_ALWAYS(a_rst_empty, !rst_ni |=> !out_valid, "output valid after reset")

  // with nothing waiting at the output the whole pipe drains, so input is open
  `M4VT_ASSERT(a_empty_ready, !out_valid |-> in_ready, "input blocked with output empty")

  // a clipped result carries at least one range limit
  `M4VT_ASSERT(a_sat_limit, out_valid && saturated |-> (out_0 == ELEM_MAX || out_0 == ELEM_MIN || out_1 == ELEM_MAX || out_1 == ELEM_MIN || out_2 == ELEM_MAX || out_2 == ELEM_MIN || out_3 == ELEM_MAX || out_3 == ELEM_MIN), "saturation flag without a clipped element")

endmodule

bind matrix4_vector_transform m4vt_checker u_m4vt_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_ready  (in_i.ready),
  .out_valid (out_o.valid),
  .out_ready (out_o.ready),
  .out_0     (out_o.out_0),
  .out_1     (out_o.out_1),
  .out_2     (out_o.out_2),
  .out_3     (out_o.out_3),
  .saturated (out_o.saturated)
);

### sim/tb_matrix4_vector_transform.sv
// ---------------------------------------------------------------------------
// tb_matrix4_vector_transform
// Self-checking bench for the 4x4 fixed point transform engine. A short
// scripted sequence of row loads and transforms covers the reset matrix, the
// identity, full-scale elements and both saturation directions. A long random
// mix of loads and transforms follows, with random idle bursts on both
// channels. Every output beat is checked field by field against the script or
// an in-bench model of the stored matrix and saturating Q16.16 dot products.
// ---------------------------------------------------------------------------
module tb_matrix4_vector_transform;
  timeunit 1ns;
  timeprecision 1ps;

  import m4vt_pkg::*;

  localparam int unsigned RANDOM_BEATS = 1800;
  localparam int unsigned DRAIN_AT     = 900;
  localparam int unsigned TAIL_FROM    = 1650;
  localparam int unsigned HOLD_CYCLES  = 60;
  localparam int unsigned HOLD_AFTER   = 200;

  localparam logic [ELEM_W-1:0] ZERO_Q  = '0;
  localparam logic [ELEM_W-1:0] ONE_Q   = 32'h0001_0000;
  localparam logic [ELEM_W-1:0] LSB_Q   = 32'h0000_0001;
  localparam logic [ELEM_W-1:0] NEG_LSB = '1;

  typedef struct packed {
    cmd_e                              command;
    logic [ROW_W-1:0]                  row;
    logic [0:NUM_ELEM-1][ELEM_W-1:0]   elem;
  } beat_t;

  typedef struct packed {
    logic [0:NUM_ELEM-1][ELEM_W-1:0]   outv;
    logic                              sat;
  } xform_t;

  typedef struct packed {
    beat_t  beat;
    logic   typed;
    xform_t want;
  } script_row_t;

  localparam xform_t NO_XFORM = '0;

  localparam script_row_t SCRIPT [21] = '{
    // matrix is all zero straight out of reset
    '{'{CMD_XFORM, 2'd0, {ELEM_MAX, ELEM_MIN, NEG_LSB, ONE_Q}}, 1'b1, NO_XFORM},
    '{'{CMD_LOAD,  2'd0, {ONE_Q, ZERO_Q, ZERO_Q, ZERO_Q}},      1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd1, {ZERO_Q, ONE_Q, ZERO_Q, ZERO_Q}},      1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd2, {ZERO_Q, ZERO_Q, ONE_Q, ZERO_Q}},      1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd3, {ZERO_Q, ZERO_Q, ZERO_Q, ONE_Q}},      1'b0, NO_XFORM},
    // identity passes the range ends through untouched
    '{'{CMD_XFORM, 2'd3, {ELEM_MAX, ELEM_MIN, NEG_LSB, ZERO_Q}}, 1'b1,
      '{{ELEM_MAX, ELEM_MIN, NEG_LSB, ZERO_Q}, 1'b0}},
    '{'{CMD_XFORM, 2'd1, {32'h1234_5678, 32'hFEDC_BA98, 32'h7FFF_0001,
                          32'h8000_FFFF}}, 1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd2, {32'h0002_8000, 32'hFFFF_8000, LSB_Q, NEG_LSB}},
      1'b0, NO_XFORM},
    '{'{CMD_XFORM, 2'd0, {32'h0003_0000, 32'hFFFD_0000, 32'h0000_8000,
                          NEG_LSB}}, 1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd0, {ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX}}, 1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd1, {ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN}}, 1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd2, {NEG_LSB, NEG_LSB, NEG_LSB, NEG_LSB}},     1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd3, {LSB_Q, ZERO_Q, ZERO_Q, ZERO_Q}},          1'b0, NO_XFORM},
    // overflow both ways in one beat
    '{'{CMD_XFORM, 2'd0, {ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX}}, 1'b0, NO_XFORM},
    '{'{CMD_XFORM, 2'd1, {ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN}}, 1'b0, NO_XFORM},
    '{'{CMD_XFORM, 2'd2, {ZERO_Q, ZERO_Q, ZERO_Q, ZERO_Q}},         1'b1, NO_XFORM},
    // tiny negative product truncates toward minus infinity
    '{'{CMD_XFORM, 2'd3, {NEG_LSB, ZERO_Q, ZERO_Q, ZERO_Q}},        1'b0, NO_XFORM},
    '{'{CMD_XFORM, 2'd0, {LSB_Q, LSB_Q, LSB_Q, LSB_Q}},             1'b0, NO_XFORM},
    '{'{CMD_LOAD,  2'd3, {32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333,
                          32'hCCCC_CCCC}}, 1'b0, NO_XFORM},
    '{'{CMD_XFORM, 2'd1, {32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC,
                          32'h3333_3333}}, 1'b0, NO_XFORM},
    '{'{CMD_XFORM, 2'd2, {ONE_Q, ONE_Q, ONE_Q, ONE_Q}},             1'b0, NO_XFORM}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  m4vt_in_if  in_if ();
  m4vt_out_if out_if ();

  matrix4_vector_transform u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  logic [ELEM_W-1:0] matrix_rows [DIM][DIM] = '{default: '0};
  xform_t            pending_xforms [$];
  int unsigned       results_seen = 0;
  int unsigned       errors_found = 0;
  bit                tail_phase   = 1'b0;

  // stored matrix times the beat's vector, shifted down and clipped
  function automatic xform_t transform_vector(input beat_t b);
    xform_t                  res;
    logic signed [ACC_W-1:0] acc, term_a, term_b, lim_hi, lim_lo;
    res    = '0;
    lim_hi = $signed(ELEM_MAX);
    lim_lo = $signed(ELEM_MIN);
    for (int r = 0; r < DIM; r++) begin
      acc = '0;
      for (int c = 0; c < DIM; c++) begin
        term_a = $signed(matrix_rows[r][c]);
        term_b = $signed(b.elem[c]);
        acc    = acc + term_a * term_b;
      end
      acc = acc >>> FRAC_BITS;
      if (acc > lim_hi) begin
        res.outv[r] = ELEM_MAX;
        res.sat     = 1'b1;
      end else if (acc < lim_lo) begin
        res.outv[r] = ELEM_MIN;
        res.sat     = 1'b1;
      end else begin
        res.outv[r] = acc[ELEM_W-1:0];
      end
    end
    return res;
  endfunction

  function automatic void take_beat(input beat_t b, input logic typed, input xform_t want);
    if (b.command == CMD_LOAD) begin
      if (b.row < DIM) begin
        for (int c = 0; c < DIM; c++) matrix_rows[b.row][c] = b.elem[c];
      end
    end else begin
      pending_xforms.push_back(typed ? want : transform_vector(b));
    end
  endfunction

  function automatic logic [ELEM_W-1:0] random_elem();
    case ($urandom_range(0, 9))
      0:       return ELEM_MAX;
      1:       return ELEM_MIN;
      2, 3:    return $urandom();
      4:       return ZERO_Q;
      default: return ELEM_W'($urandom_range(0, 1 << 20) - (1 << 19));  // within +-8.0
    endcase
  endfunction

  function automatic beat_t random_beat();
    beat_t b;
    b.command = ($urandom_range(0, 3) == 0) ? CMD_LOAD : CMD_XFORM;
    b.row     = ROW_W'($urandom_range(0, 3));
    for (int k = 0; k < NUM_ELEM; k++) b.elem[k] = random_elem();
    return b;
  endfunction

  // holds the beat on the channel until the engine takes it
  task automatic offer_beat(input beat_t b);
    in_if.valid     <= 1'b1;
    in_if.command   <= b.command;
    in_if.row_index <= b.row;
    in_if.elem_0    <= b.elem[0];
    in_if.elem_1    <= b.elem[1];
    in_if.elem_2    <= b.elem[2];
    in_if.elem_3    <= b.elem[3];
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  task automatic idle_burst(input int unsigned gap_pct);
    if (!tail_phase && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  // source side
  initial begin
    beat_t       b;
    int unsigned gap_pct;
    rst_ni          <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.command   <= CMD_LOAD;
    in_if.row_index <= '0;
    in_if.elem_0    <= '0;
    in_if.elem_1    <= '0;
    in_if.elem_2    <= '0;
    in_if.elem_3    <= '0;
    gap_pct = 20;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (SCRIPT[i]) begin
      offer_beat(SCRIPT[i].beat);
      take_beat(SCRIPT[i].beat, SCRIPT[i].typed, SCRIPT[i].want);
      idle_burst(gap_pct);
    end

    for (int unsigned i = 0; i < RANDOM_BEATS; i++) begin
      if (i % 150 == 0) begin
        case ($urandom_range(0, 2))
          0:       gap_pct = 0;
          1:       gap_pct = 15;
          default: gap_pct = 40;
        endcase
      end
      if (i == TAIL_FROM) tail_phase = 1'b1;
      if (i == DRAIN_AT) begin
        // let the engine run dry before carrying on
        in_if.valid <= 1'b0;
        do @(posedge clk_i); while (pending_xforms.size() != 0);
      end
      b = random_beat();
      offer_beat(b);
      take_beat(b, 1'b0, NO_XFORM);
      idle_burst(gap_pct);
    end

    in_if.valid <= 1'b0;
    while (pending_xforms.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (errors_found == 0) begin
      $display("PASS matrix4_vector_transform");
    end else begin
      $display("FAIL matrix4_vector_transform");
    end
    $finish;
  end

  // sink side: random stalls, one long hold-off, steady in the tail
  initial begin
    bit held;
    held = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (tail_phase) begin
        out_if.ready <= 1'b1;
        @(posedge clk_i);
      end else if (!held && results_seen >= HOLD_AFTER) begin
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    xform_t want, got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      got = '{{out_if.out_0, out_if.out_1, out_if.out_2, out_if.out_3}, out_if.saturated};
      if (pending_xforms.size() == 0) begin
        $error("result beat with no transform pending");
        errors_found++;
      end else begin
        want = pending_xforms.pop_front();
        for (int k = 0; k < NUM_ELEM; k++) begin
          if (got.outv[k] !== want.outv[k]) begin
            $error("out_%0d: expected %h, got %h", k, want.outv[k], got.outv[k]);
            errors_found++;
          end
        end
        if (got.sat !== want.sat) begin
          $error("saturated: expected %b, got %b", want.sat, got.sat);
          errors_found++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("FAIL matrix4_vector_transform");
    $finish;
  end

endmodule
